// ----- rtl/bfra_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfra_pkg
// Shared types and constants for the best-fit region allocator.
// ----------------------------------------------------------------------------
package bfra_pkg;

    localparam int MEM_BYTES    = 64 * 1024;
    localparam int MAX_SEGMENTS = 64;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int OFF_W        = 16;
    localparam int LEN_W        = 17;
    localparam int TAG_W        = 3;

    localparam logic [TAG_W-1:0] TAG_FREE = '0;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADREF = 2'd3;

    // one segment table entry
    typedef struct packed {
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } t_seg;

    localparam int SEG_W = $bits(t_seg);

endpackage
`default_nettype wire

// ----- rtl/bfra_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bfra_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bfra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- rtl/best_fit_region_allocator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// best_fit_region_allocator
// Best-fit allocator with coalescing; segment table held in one RAM.
// ----------------------------------------------------------------------------
// Flow: a scan reads the N live segments in order, one table read per cycle.
// An exact fit or an error then answers at once; a split that inserts an
// entry or a free that removes entries first shifts the entries above it.
// One item is processed at a time; results sit in an output register.
// Reset: synchronous; after reset the S_INIT state writes the initial free
// segment into entry 0, during which no item is taken.
module best_fit_region_allocator
    import bfra_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_command,
    input  wire logic [TAG_W-1:0]  i_usage_tag,
    input  wire logic [LEN_W-1:0]  i_request_size,
    input  wire logic [OFF_W-1:0]  i_region_offset,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [1:0]             o_status,
    output logic [OFF_W-1:0]       o_granted_offset,
    output logic [LEN_W-1:0]       o_segment_size
);

    typedef enum logic [7:0] {
        S_INIT   = 8'b0000_0001,
        S_IDLE   = 8'b0000_0010,
        S_SCAN   = 8'b0000_0100,
        S_DECIDE = 8'b0000_1000,
        S_COPY   = 8'b0001_0000,
        S_FIX1   = 8'b0010_0000,
        S_FIX2   = 8'b0100_0000,
        S_RESP   = 8'b1000_0000
    } t_state;

    t_state r_state;

    // request
    logic             r_cmd;
    logic [TAG_W-1:0] r_tag;
    logic [LEN_W-1:0] r_size;
    logic [OFF_W-1:0] r_off;
    logic [CNT_W-1:0] r_count;

    // scan pipeline
    logic [CNT_W-1:0] r_ridx;
    logic             r_sv;
    logic [IDX_W-1:0] r_sidx;
    t_seg             r_last;

    // scan results
    logic             r_found;
    logic [IDX_W-1:0] r_bidx;
    logic [OFF_W-1:0] r_boff;
    logic [LEN_W-1:0] r_blen;
    logic [LEN_W-1:0] r_bleft;
    logic [TAG_W-1:0] r_btag;
    logic             r_pf;
    logic [OFF_W-1:0] r_poff;
    logic [LEN_W-1:0] r_plen;
    logic             r_nf;
    logic [LEN_W-1:0] r_nlen;
    logic [IDX_W-1:0] r_tidx;
    logic [LEN_W-1:0] r_mlen;

    // copy engine
    logic [CNT_W-1:0] r_src;
    logic [CNT_W-1:0] r_dst;
    logic [CNT_W-1:0] r_rleft;
    logic             r_down;
    logic             r_wv;
    logic [IDX_W-1:0] r_wa;

    // pending and output result
    logic [1:0]       r_rst;
    logic [OFF_W-1:0] r_roff;
    logic [LEN_W-1:0] r_rlen;
    logic             r_ov;
    logic [1:0]       r_ost;
    logic [OFF_W-1:0] r_ooff;
    logic [LEN_W-1:0] r_olen;

    // RAM port signals
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_seg             ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_seg             ram_rdata;
    logic [SEG_W-1:0] ram_rbits;

    logic             in_xfer;
    logic             out_free;
    logic [LEN_W-1:0] d_left;
    logic             d_fit;
    logic [IDX_W-1:0] bidx_p1;

    assign in_xfer   = i_valid && !o_stall;
    assign out_free  = !r_ov || !i_stall;
    assign ram_rdata = t_seg'(ram_rbits);
    assign d_left    = ram_rdata.len - r_size;
    assign d_fit     = (ram_rdata.tag == TAG_FREE) && (ram_rdata.len >= r_size);
    assign bidx_p1   = r_bidx + IDX_W'(1);

    // RAM address and write selection
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_wa;
        ram_wdata = ram_rdata;
        ram_raddr = (r_state == S_COPY) ? r_src[IDX_W-1:0] : r_ridx[IDX_W-1:0];
        unique case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = '{off: '0, len: LEN_W'(MEM_BYTES), tag: TAG_FREE};
            end
            S_DECIDE: begin
                // exact fit: retag in place
                ram_we    = (r_cmd == CMD_ALLOC) && (r_size != '0) && r_found
                            && (r_bleft == '0);
                ram_waddr = r_bidx;
                ram_wdata = '{off: r_boff, len: r_blen, tag: r_tag};
            end
            S_COPY: begin
                ram_we = r_wv;
            end
            S_FIX1: begin
                ram_we = 1'b1;
                if (r_cmd == CMD_ALLOC) begin
                    ram_waddr = bidx_p1;
                    ram_wdata = '{off: r_boff + r_size[OFF_W-1:0], len: r_bleft,
                                  tag: TAG_FREE};
                end else begin
                    ram_waddr = r_tidx;
                    ram_wdata = '{off: r_roff, len: r_mlen, tag: TAG_FREE};
                end
            end
            S_FIX2: begin
                ram_we    = 1'b1;
                ram_waddr = r_bidx;
                ram_wdata = '{off: r_boff, len: r_size, tag: r_tag};
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    bfra_ram #(
        .WIDTH(SEG_W),
        .DEPTH(MAX_SEGMENTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rbits)
    );

    // control sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_count <= '0;
            r_sv    <= 1'b0;
            r_wv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            // output drained; a new load in S_RESP keeps it set
            if (r_ov && !i_stall && r_state != S_RESP) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_count <= CNT_W'(1);
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (in_xfer) begin
                        r_cmd   <= i_command;
                        r_tag   <= (i_usage_tag == TAG_FREE) ? TAG_W'(1) : i_usage_tag;
                        r_size  <= i_request_size;
                        r_off   <= i_region_offset;
                        r_ridx  <= '0;
                        r_sv    <= 1'b0;
                        r_found <= 1'b0;
                        r_pf    <= 1'b0;
                        r_nf    <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // issue reads in order; data returns in the following cycle
                    r_sv   <= (r_ridx != r_count);
                    r_sidx <= r_ridx[IDX_W-1:0];
                    if (r_ridx != r_count) begin
                        r_ridx <= r_ridx + CNT_W'(1);
                    end
                    if (r_sv) begin
                        r_last <= ram_rdata;
                        if (r_cmd == CMD_ALLOC) begin
                            if (d_fit && (!r_found || d_left < r_bleft)) begin
                                r_found <= 1'b1;
                                r_bidx  <= r_sidx;
                                r_boff  <= ram_rdata.off;
                                r_blen  <= ram_rdata.len;
                                r_bleft <= d_left;
                            end
                        end else begin
                            if (!r_found && ram_rdata.off == r_off) begin
                                r_found <= 1'b1;
                                r_bidx  <= r_sidx;
                                r_boff  <= ram_rdata.off;
                                r_blen  <= ram_rdata.len;
                                r_btag  <= ram_rdata.tag;
                                r_pf    <= (r_sidx != '0) && (r_last.tag == TAG_FREE);
                                r_poff  <= r_last.off;
                                r_plen  <= r_last.len;
                            end
                            if (r_found && r_sidx == bidx_p1) begin
                                r_nf   <= (ram_rdata.tag == TAG_FREE);
                                r_nlen <= ram_rdata.len;
                            end
                        end
                    end
                    if (!r_sv && r_ridx == r_count) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_cmd == CMD_ALLOC) begin
                        if (r_size == '0 || !r_found) begin
                            r_rst   <= ST_NOFIT;
                            r_roff  <= '0;
                            r_rlen  <= '0;
                            r_state <= S_RESP;
                        end else if (r_bleft == '0) begin
                            r_rst   <= ST_OK;
                            r_roff  <= r_boff;
                            r_rlen  <= r_size;
                            r_state <= S_RESP;
                        end else if (r_count == CNT_W'(MAX_SEGMENTS)) begin
                            r_rst   <= ST_FULL;
                            r_roff  <= '0;
                            r_rlen  <= '0;
                            r_state <= S_RESP;
                        end else begin
                            // open a hole above the best fit
                            r_rst   <= ST_OK;
                            r_src   <= r_count - CNT_W'(1);
                            r_dst   <= r_count;
                            r_rleft <= r_count - CNT_W'(1) - CNT_W'(r_bidx);
                            r_down  <= 1'b1;
                            r_roff  <= r_boff;
                            r_rlen  <= r_size;
                            r_state <= S_COPY;
                        end
                    end else begin
                        if (!r_found || r_btag == TAG_FREE) begin
                            r_rst   <= ST_BADREF;
                            r_roff  <= '0;
                            r_rlen  <= '0;
                            r_state <= S_RESP;
                        end else begin
                            // close the gap left by merged neighbors
                            r_rst   <= ST_OK;
                            r_tidx  <= r_pf ? r_bidx - IDX_W'(1) : r_bidx;
                            r_src   <= CNT_W'(r_bidx) + CNT_W'(1) + CNT_W'(r_nf);
                            r_rleft <= r_count - (CNT_W'(r_bidx) + CNT_W'(1)
                                       + CNT_W'(r_nf));
                            r_dst   <= (r_pf ? CNT_W'(r_bidx) : CNT_W'(r_bidx)
                                       + CNT_W'(1));
                            r_down  <= 1'b0;
                            r_mlen  <= r_blen + (r_nf ? r_nlen : '0)
                                       + (r_pf ? r_plen : '0);
                            r_roff  <= r_pf ? r_poff : r_boff;
                            r_rlen  <= r_blen + (r_nf ? r_nlen : '0)
                                       + (r_pf ? r_plen : '0);
                            r_state <= S_COPY;
                        end
                    end
                end
                S_COPY: begin
                    // streamed move: read one entry, write it in the next cycle
                    if (r_rleft != '0) begin
                        r_rleft <= r_rleft - CNT_W'(1);
                        r_wv    <= 1'b1;
                        r_wa    <= r_dst[IDX_W-1:0];
                        r_src   <= r_down ? r_src - CNT_W'(1) : r_src + CNT_W'(1);
                        r_dst   <= r_down ? r_dst - CNT_W'(1) : r_dst + CNT_W'(1);
                    end else begin
                        r_wv <= 1'b0;
                        if (!r_wv) begin
                            r_state <= S_FIX1;
                        end
                    end
                end
                S_FIX1: begin
                    if (r_cmd == CMD_ALLOC) begin
                        r_state <= S_FIX2;
                    end else begin
                        r_count <= r_count - CNT_W'(r_pf) - CNT_W'(r_nf);
                        r_state <= S_RESP;
                    end
                end
                S_FIX2: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_RESP;
                end
                S_RESP: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_ost   <= r_rst;
                        r_ooff  <= r_roff;
                        r_olen  <= r_rlen;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_INIT;
                end
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ov;
    assign o_status         = r_ost;
    assign o_granted_offset = r_ooff;
    assign o_segment_size   = r_olen;

    // checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INIT) |-> (r_count != '0 && r_count <= CNT_W'(MAX_SEGMENTS)))
        else $error("segment count out of range");

    a_copy_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wv |-> (r_state == S_COPY))
        else $error("copy write outside copy phase");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_state == S_SCAN))
        else $error("accepted transfer did not start a scan");

    a_resp_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP && out_free) |=> r_ov)
        else $error("result not loaded into output register");

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Best-fit region allocator bench
// Drives allocate and free requests through the valid/stall input channel,
// predicts each status, offset and size with a private copy of the segment
// table, and compares every output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    import bfra_pkg::*;

    localparam int N_RANDOM = 1600;

    // one request or one expected/actual response
    typedef struct {
        logic             cmd;
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] size;
        logic [OFF_W-1:0] off;
        bit               typed;   // a typed-in answer is given below
        logic [1:0]       st;
        logic [OFF_W-1:0] g_off;
        logic [LEN_W-1:0] g_len;
    } t_req;

    typedef struct {
        logic [1:0]       st;
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] len;
    } t_resp;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             i_command = CMD_ALLOC;
    logic [TAG_W-1:0] i_usage_tag = '0;
    logic [LEN_W-1:0] i_request_size = '0;
    logic [OFF_W-1:0] i_region_offset = '0;
    logic             i_stall = 1'b0;
    logic             o_stall;
    logic             o_valid;
    logic [1:0]       o_status;
    logic [OFF_W-1:0] o_granted_offset;
    logic [LEN_W-1:0] o_segment_size;

    // predicted segment table
    logic [OFF_W-1:0] tbl_off [MAX_SEGMENTS];
    logic [LEN_W-1:0] tbl_len [MAX_SEGMENTS];
    logic [TAG_W-1:0] tbl_tag [MAX_SEGMENTS];
    int               tbl_cnt;

    t_resp pending_resp[$];
    int    n_errors = 0;
    bit    calm = 1'b0;      // no idling in the last stretch

    best_fit_region_allocator uut (.*);

    always #5 i_clk = ~i_clk;

    // remove one table entry and close the gap
    function automatic void tbl_drop(int idx);
        for (int k = idx; k < tbl_cnt - 1; k++) begin
            tbl_off[k] = tbl_off[k+1];
            tbl_len[k] = tbl_len[k+1];
            tbl_tag[k] = tbl_tag[k+1];
        end
        tbl_cnt--;
    endfunction

    // best-fit allocate / coalescing free over the predicted table
    function automatic t_resp predict_region(logic cmd, logic [TAG_W-1:0] tag,
                                             logic [LEN_W-1:0] size,
                                             logic [OFF_W-1:0] off);
        t_resp r;
        int    best;
        int    best_left;
        int    i;
        bit    found;
        r = '{ST_OK, '0, '0};
        best = 0;
        best_left = 0;
        found = 1'b0;
        if (cmd == CMD_ALLOC) begin
            if (tag == TAG_FREE) tag = TAG_W'(1);
            if (size == 0) begin
                r.st = ST_NOFIT;
                return r;
            end
            for (i = 0; i < tbl_cnt; i++) begin
                if (tbl_tag[i] != TAG_FREE || tbl_len[i] < size) continue;
                if (!found || int'(tbl_len[i]) - int'(size) < best_left) begin
                    found = 1'b1;
                    best = i;
                    best_left = int'(tbl_len[i]) - int'(size);
                end
            end
            if (!found) begin
                r.st = ST_NOFIT;
                return r;
            end
            if (best_left != 0) begin
                if (tbl_cnt >= MAX_SEGMENTS) begin
                    r.st = ST_FULL;
                    return r;
                end
                for (int k = tbl_cnt; k > best + 1; k--) begin
                    tbl_off[k] = tbl_off[k-1];
                    tbl_len[k] = tbl_len[k-1];
                    tbl_tag[k] = tbl_tag[k-1];
                end
                tbl_off[best+1] = tbl_off[best] + OFF_W'(size);
                tbl_len[best+1] = LEN_W'(best_left);
                tbl_tag[best+1] = TAG_FREE;
                tbl_len[best] = size;
                tbl_cnt++;
            end
            tbl_tag[best] = tag;
            r.off = tbl_off[best];
            r.len = size;
        end else begin
            for (i = 0; i < tbl_cnt; i++) begin
                if (tbl_off[i] == off) begin
                    found = tbl_tag[i] != TAG_FREE;
                    break;
                end
            end
            if (!found) begin
                r.st = ST_BADREF;
                return r;
            end
            tbl_tag[i] = TAG_FREE;
            if (i + 1 < tbl_cnt && tbl_tag[i+1] == TAG_FREE) begin
                tbl_len[i] += tbl_len[i+1];
                tbl_drop(i + 1);
            end
            if (i > 0 && tbl_tag[i-1] == TAG_FREE) begin
                tbl_len[i-1] += tbl_len[i];
                tbl_drop(i);
                i--;
            end
            r.off = tbl_off[i];
            r.len = tbl_len[i];
        end
        return r;
    endfunction

    // drive one request transfer, with random idle bursts ahead of it
    task automatic send_request(t_req q);
        t_resp r;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_command       <= q.cmd;
        i_usage_tag     <= q.tag;
        i_request_size  <= q.size;
        i_region_offset <= q.off;
        do @(posedge i_clk); while (o_stall);
        r = predict_region(q.cmd, q.tag, q.size, q.off);
        if (q.typed && (r.st != q.st || r.off != q.g_off || r.len != q.g_len)) begin
            $display("%0t: table answer differs from prediction: exp %0d/%0h/%0h got %0d/%0h/%0h",
                     $time, q.st, q.g_off, q.g_len, r.st, r.off, r.len);
            n_errors++;
        end
        if (q.typed) r = '{q.st, q.g_off, q.g_len};
        pending_resp.push_back(r);
    endtask

    // response-side stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (!calm && i_rst_n && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_resp.size() == 0) begin
                $display("%0t: unexpected response %0d/%0h/%0h", $time,
                         o_status, o_granted_offset, o_segment_size);
                n_errors++;
            end else begin
                t_resp e;
                e = pending_resp.pop_front();
                if (o_status !== e.st) begin
                    $display("%0t: status exp %0d got %0d", $time, e.st, o_status);
                    n_errors++;
                end
                if (o_granted_offset !== e.off) begin
                    $display("%0t: offset exp %0h got %0h", $time, e.off, o_granted_offset);
                    n_errors++;
                end
                if (o_segment_size !== e.len) begin
                    $display("%0t: size exp %0h got %0h", $time, e.len, o_segment_size);
                    n_errors++;
                end
            end
        end
    end

    // pick a table entry's offset, sometimes shifted by 1 to 3, or a random one now and then
    function automatic logic [OFF_W-1:0] pick_offset();
        int k;
        if ($urandom_range(0, 9) == 0) return OFF_W'($urandom);
        k = $urandom_range(0, tbl_cnt - 1);
        if ($urandom_range(0, 5) == 0) return tbl_off[k] + OFF_W'($urandom_range(1, 3));
        return tbl_off[k];
    endfunction

    initial begin
        t_req dir_tbl[$];
        t_req q;
        int   wait_cyc;

        // directed rows: typed answers only where obvious
        dir_tbl = '{
            '{CMD_ALLOC, 3'd1, 17'd0,     16'd0,     1, ST_NOFIT,  16'd0, 17'd0},
            '{CMD_ALLOC, 3'd7, 17'h1FFFF, 16'hFFFF,  1, ST_NOFIT,  16'd0, 17'd0},
            '{CMD_ALLOC, 3'd2, 17'd65537, 16'd0,     1, ST_NOFIT,  16'd0, 17'd0},
            '{CMD_FREE,  3'd0, 17'd0,     16'd0,     1, ST_BADREF, 16'd0, 17'd0},
            '{CMD_FREE,  3'd7, 17'h1FFFF, 16'hFFFF,  1, ST_BADREF, 16'd0, 17'd0},
            '{CMD_ALLOC, 3'd5, 17'd65536, 16'd0,     1, ST_OK,     16'd0, 17'd65536},
            '{CMD_ALLOC, 3'd1, 17'd1,     16'd0,     1, ST_NOFIT,  16'd0, 17'd0},
            '{CMD_FREE,  3'd0, 17'd0,     16'd0,     1, ST_OK,     16'd0, 17'd65536},
            '{CMD_ALLOC, 3'd0, 17'd1,     16'd0,     1, ST_OK,     16'd0, 17'd1},
            '{CMD_ALLOC, 3'd7, 17'd16,    16'd0,     1, ST_OK,     16'd1, 17'd16},
            '{CMD_ALLOC, 3'd4, 17'd100,   16'd0,     0, 0, 0, 0},
            '{CMD_FREE,  3'd0, 17'd0,     16'd1,     0, 0, 0, 0},
            '{CMD_FREE,  3'd0, 17'd0,     16'd1,     1, ST_BADREF, 16'd0, 17'd0},
            '{CMD_ALLOC, 3'd3, 17'd16,    16'd0,     0, 0, 0, 0},
            '{CMD_FREE,  3'd0, 17'd0,     16'd17,    0, 0, 0, 0},
            '{CMD_FREE,  3'd0, 17'd0,     16'd0,     0, 0, 0, 0},
            '{CMD_FREE,  3'd0, 17'd0,     16'd1,     0, 0, 0, 0},
            '{CMD_FREE,  3'd0, 17'd0,     16'd2,     1, ST_BADREF, 16'd0, 17'd0}
        };

        tbl_off = '{default: '0};
        tbl_len = '{default: '0};
        tbl_tag = '{default: '0};
        tbl_len[0] = LEN_W'(MEM_BYTES);
        tbl_cnt = 1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tbl[n]) send_request(dir_tbl[n]);

        // fill the table to the limit to reach the full-table case
        for (int n = 0; n < MAX_SEGMENTS + 2; n++)
            send_request('{CMD_ALLOC, TAG_W'($urandom_range(1, 7)),
                           LEN_W'($urandom_range(1, 8)), 16'd0, 0, 0, 0, 0});

        // random mix; the bias between allocate and free drifts by phase
        for (int n = 0; n < N_RANDOM; n++) begin
            int fr;
            if (n > N_RANDOM - 200) calm = 1'b1;
            fr = ((n / 200) % 2) ? 60 : 35;
            q = '{default: '0};
            q.tag  = TAG_W'($urandom);
            q.size = LEN_W'($urandom);
            q.off  = OFF_W'($urandom);
            q.cmd  = ($urandom_range(0, 99) < fr) ? CMD_FREE : CMD_ALLOC;
            if (q.cmd == CMD_FREE) q.off = pick_offset();
            else case ($urandom_range(0, 9))
                0:       q.size = LEN_W'($urandom_range(0, 65536));
                1:       q.size = LEN_W'($urandom_range(2000, 20000));
                2:       q.size = tbl_len[$urandom_range(0, tbl_cnt - 1)];
                default: q.size = LEN_W'($urandom_range(1, 600));
            endcase
            send_request(q);
        end
        i_valid <= 1'b0;

        wait_cyc = 0;
        while (pending_resp.size() != 0 && wait_cyc < 100000) begin
            @(posedge i_clk);
            wait_cyc++;
        end
        repeat (2 * MAX_SEGMENTS + 20) @(posedge i_clk);

        if (n_errors == 0 && pending_resp.size() == 0) begin
            $display("Regression PASS");
        end else begin
            if (pending_resp.size() != 0)
                $display("%0t: %0d responses never arrived", $time, pending_resp.size());
            $display("Regression FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
